// ===== hw/rtl/cpt_pkg.sv =====
// ----------------------------------------------------------------------------
// cpt_pkg - copy propagation table package
// Types, sizes and helpers shared by the copy table cells, head and top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cpt_pkg;

  localparam int LOC_BITS     = 16;
  localparam int OFFSET_BITS  = 4;
  localparam int REG_BITS     = LOC_BITS - OFFSET_BITS;
  localparam int COUNT_BITS   = 4;
  localparam int IO_SOURCES   = 3;
  localparam int SOURCE_COUNT = 3;
  localparam int NSRC         = (SOURCE_COUNT < IO_SOURCES) ? SOURCE_COUNT : IO_SOURCES;
  localparam int TABLE_DEPTH  = 16;

  typedef logic [LOC_BITS-1:0] loc_t;
  typedef logic [IO_SOURCES-1:0][LOC_BITS-1:0] src_vec_t;

  typedef struct packed {
    logic                  block_start;
    logic                  is_move;
    logic                  copy_ok;
    logic                  dest_in_grf;
    loc_t                  dest_loc;
    logic [COUNT_BITS-1:0] dest_count;
    logic                  src0_in_grf;
    loc_t                  src0_loc;
    logic                  src1_in_grf;
    loc_t                  src1_loc;
    logic                  src2_in_grf;
    loc_t                  src2_loc;
  } cpt_in_t;

  typedef struct packed {
    loc_t new_src0_loc;
    loc_t new_src1_loc;
    loc_t new_src2_loc;
    logic any_rewritten;
  } cpt_out_t;

  typedef struct packed {
    loc_t dest;
    loc_t src;
  } cpt_entry_t;

  typedef struct packed {
    logic shift;
    logic wr;
  } cpt_cell_ctrl_t;

  typedef struct packed {
    logic                   en;
    logic [REG_BITS-1:0]    reg_num;
    logic [OFFSET_BITS-1:0] first;
    logic [COUNT_BITS-1:0]  count;
  } cpt_kill_t;

  typedef struct packed {
    logic survive;
    logic hit;
  } cpt_head_stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PASS,
    ST_FINISH
  } cpt_state_t;

  function automatic logic in_range(input loc_t loc, input cpt_kill_t kill);
    logic [OFFSET_BITS:0] off;
    logic [OFFSET_BITS:0] lim;
    off = {1'b0, loc[OFFSET_BITS-1:0]};
    lim = {1'b0, kill.first} + {{(OFFSET_BITS+1-COUNT_BITS){1'b0}}, kill.count};
    return (loc[LOC_BITS-1:OFFSET_BITS] == kill.reg_num) &&
           (off >= {1'b0, kill.first}) && (off < lim);
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/copy_propagation_table_top.sv =====
// ----------------------------------------------------------------------------
// copy_propagation_table_top - local copy propagation table
// Copies sit oldest first in a row of cells; a pass rotates each live copy
// through the head unit once, dropping killed copies, then may append a new copy.
// ----------------------------------------------------------------------------
// flow: an accepted item is registered, each live copy (up to TABLE_DEPTH) passes
//   the head unit in ST_PASS, then ST_FINISH appends any new copy and registers
//   the result, waiting while the result is not taken; no new item until idle
// reset: table empty, no result pending; no clearing pass is needed
`timescale 1ns / 1ps
`default_nettype none

module copy_propagation_table_top #(
  parameter int TABLE_DEPTH = cpt_pkg::TABLE_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output logic                   item_ready,
  input  wire cpt_pkg::cpt_in_t  item,
  output logic                   result_valid,
  input  wire logic              result_ready,
  output cpt_pkg::cpt_out_t      result
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int OCC_W = $clog2(TABLE_DEPTH + 1);

  cpt_pkg::cpt_state_t     state;
  cpt_pkg::cpt_state_t     state_next;
  logic [OCC_W-1:0]        occ;
  logic [OCC_W-1:0]        pass_left;
  cpt_pkg::cpt_in_t        item_reg;
  cpt_pkg::src_vec_t       src_work;
  logic                    any_work;

  cpt_pkg::cpt_entry_t     entries [TABLE_DEPTH];
  cpt_pkg::cpt_entry_t     push;
  cpt_pkg::src_vec_t       head_loc;
  cpt_pkg::cpt_head_stat_t head_stat;
  cpt_pkg::cpt_kill_t      kill;

  logic                    accept;
  logic                    out_free;
  logic                    finish_load;
  logic                    append_ok;
  logic                    shift;
  logic                    wr_en;
  logic [OCC_W-1:0]        wr_pos;
  logic [OCC_W-1:0]        start_count;

  assign accept      = item_valid && item_ready;
  assign out_free    = !result_valid || result_ready;
  assign start_count = item.block_start ? '0 : occ;

  assign kill.en      = item_reg.dest_in_grf && (item_reg.dest_count != '0);
  assign kill.reg_num = item_reg.dest_loc[cpt_pkg::LOC_BITS-1:cpt_pkg::OFFSET_BITS];
  assign kill.first   = item_reg.dest_loc[cpt_pkg::OFFSET_BITS-1:0];
  assign kill.count   = item_reg.dest_count;

  assign append_ok = item_reg.is_move && item_reg.copy_ok && item_reg.dest_in_grf &&
                     item_reg.src0_in_grf && (src_work[0] != item_reg.dest_loc) &&
                     (occ < OCC_W'(TABLE_DEPTH));

  cpt_head u_head (
    .entry   (entries[0]),
    .src_grf ({item_reg.src2_in_grf, item_reg.src1_in_grf, item_reg.src0_in_grf}),
    .src_loc (src_work),
    .kill    (kill),
    .new_loc (head_loc),
    .stat    (head_stat)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cpt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      cpt_pkg::ST_IDLE: begin
        if (item_valid) begin
          state_next = (start_count == '0) ? cpt_pkg::ST_FINISH : cpt_pkg::ST_PASS;
        end
      end
      cpt_pkg::ST_PASS: begin
        if (pass_left == OCC_W'(1)) begin
          state_next = cpt_pkg::ST_FINISH;
        end
      end
      cpt_pkg::ST_FINISH: begin
        if (out_free) begin
          state_next = cpt_pkg::ST_IDLE;
        end
      end
      default: state_next = cpt_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    item_ready  = 1'b0;
    shift       = 1'b0;
    wr_en       = 1'b0;
    wr_pos      = occ;
    finish_load = 1'b0;
    push        = entries[0];
    case (state)
      cpt_pkg::ST_IDLE: begin
        item_ready = 1'b1;
      end
      cpt_pkg::ST_PASS: begin
        shift  = 1'b1;
        wr_en  = head_stat.survive;
        wr_pos = occ - OCC_W'(1);
      end
      cpt_pkg::ST_FINISH: begin
        finish_load = out_free;
        wr_en       = out_free && append_ok;
        push.dest   = item_reg.dest_loc;
        push.src    = src_work[0];
      end
      default: begin
        item_ready = 1'b0;
      end
    endcase
  end

  // cell row
  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    cpt_pkg::cpt_cell_ctrl_t ctrl;
    cpt_pkg::cpt_entry_t     right;

    assign ctrl.shift = shift;
    assign ctrl.wr    = wr_en && (wr_pos[IDX_W-1:0] == IDX_W'(g));

    if (g == TABLE_DEPTH - 1) begin : g_tail
      assign right = entries[g];
    end else begin : g_body
      assign right = entries[g+1];
    end

    cpt_cell u_cell (
      .clk   (clk),
      .ctrl  (ctrl),
      .right (right),
      .push  (push),
      .entry (entries[g])
    );
  end

  // control counters
  always_ff @(posedge clk) begin
    if (rst) begin
      occ       <= '0;
      pass_left <= '0;
    end else begin
      case (state)
        cpt_pkg::ST_IDLE: begin
          if (accept) begin
            occ       <= start_count;
            pass_left <= start_count;
          end
        end
        cpt_pkg::ST_PASS: begin
          occ       <= occ - OCC_W'(1) + OCC_W'(head_stat.survive);
          pass_left <= pass_left - OCC_W'(1);
        end
        cpt_pkg::ST_FINISH: begin
          if (finish_load && append_ok) begin
            occ <= occ + OCC_W'(1);
          end
        end
        default: begin
          occ <= occ;
        end
      endcase
    end
  end

  // item and working sources
  always_ff @(posedge clk) begin
    if (accept) begin
      item_reg <= item;
      src_work <= {item.src2_loc, item.src1_loc, item.src0_loc};
      any_work <= 1'b0;
    end else if (shift) begin
      src_work <= head_loc;
      any_work <= any_work | head_stat.hit;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (finish_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish_load) begin
      result.new_src0_loc  <= src_work[0];
      result.new_src1_loc  <= src_work[1];
      result.new_src2_loc  <= src_work[2];
      result.any_rewritten <= any_work;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/cpt_cell.sv =====
// ----------------------------------------------------------------------------
// cpt_cell - copy table cell
// Holds one copy; loads a pushed copy, takes its neighbor's copy, or holds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cpt_cell (
  input  wire logic               clk,
  input  wire cpt_pkg::cpt_cell_ctrl_t ctrl,
  input  wire cpt_pkg::cpt_entry_t     right,
  input  wire cpt_pkg::cpt_entry_t     push,
  output cpt_pkg::cpt_entry_t          entry
);

  always_ff @(posedge clk) begin
    if (ctrl.wr) begin
      entry <= push;
    end else if (ctrl.shift) begin
      entry <= right;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/cpt_head.sv =====
// ----------------------------------------------------------------------------
// cpt_head - copy table head unit
// Rewrites the sources through the oldest copy and decides whether it survives.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cpt_head (
  input  wire cpt_pkg::cpt_entry_t            entry,
  input  wire logic [cpt_pkg::IO_SOURCES-1:0] src_grf,
  input  wire cpt_pkg::src_vec_t              src_loc,
  input  wire cpt_pkg::cpt_kill_t             kill,
  output cpt_pkg::src_vec_t                   new_loc,
  output cpt_pkg::cpt_head_stat_t             stat
);

  always_comb begin
    new_loc  = src_loc;
    stat.hit = 1'b0;
    for (int i = 0; i < cpt_pkg::IO_SOURCES; i++) begin
      if ((i < cpt_pkg::NSRC) && src_grf[i] && (src_loc[i] == entry.dest)) begin
        new_loc[i] = entry.src;
        stat.hit   = 1'b1;
      end
    end
    stat.survive = !(kill.en && (cpt_pkg::in_range(entry.dest, kill) ||
                                 cpt_pkg::in_range(entry.src, kill)));
  end

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench - copy propagation table
// Drives instructions into the copy table over a valid/ready channel and
// checks every rewritten-source result against a local model of the table of
// available copies. A directed opening covers chained rewrites, non-register
// sources, kill ranges at the register edge, zero-count writes, self moves
// and a full table. Biased random instructions follow, with random idling on
// both channels and one long result stall that backs up the input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import cpt_pkg::*;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     item_valid = 1'b0;
  logic     item_ready;
  cpt_in_t  item = '0;
  logic     result_valid;
  logic     result_ready = 1'b0;
  cpt_out_t result;

  bit idling_on = 1'b0;

  class copy_prop_sb;
    cpt_entry_t avail_copies[$];
    cpt_out_t   expected_rewrites[$];
    int         accepted = 0;
    int         results_seen = 0;
    int         errors = 0;

    function bit hits_range(loc_t loc, cpt_in_t x);
      int off;
      int first;
      off = int'(loc[OFFSET_BITS-1:0]);
      first = int'(x.dest_loc[OFFSET_BITS-1:0]);
      return (loc[LOC_BITS-1:OFFSET_BITS] == x.dest_loc[LOC_BITS-1:OFFSET_BITS]) &&
             (off >= first) && (off < first + int'(x.dest_count));
    endfunction

    function void note_instr(cpt_in_t x);
      loc_t       loc[IO_SOURCES];
      logic       grf[IO_SOURCES];
      logic       hit;
      cpt_entry_t kept[$];
      cpt_entry_t fresh;
      cpt_out_t   r;
      int         i;
      loc[0] = x.src0_loc;
      loc[1] = x.src1_loc;
      loc[2] = x.src2_loc;
      grf[0] = x.src0_in_grf;
      grf[1] = x.src1_in_grf;
      grf[2] = x.src2_in_grf;
      hit = 1'b0;
      if (x.block_start) avail_copies.delete();
      // oldest copy first, so chains resolve
      foreach (avail_copies[k]) begin
        for (i = 0; i < NSRC; i++) begin
          if (grf[i] && loc[i] == avail_copies[k].dest) begin
            loc[i] = avail_copies[k].src;
            hit = 1'b1;
          end
        end
      end
      if (x.dest_in_grf && x.dest_count != 0) begin
        foreach (avail_copies[k]) begin
          if (!hits_range(avail_copies[k].dest, x) && !hits_range(avail_copies[k].src, x))
            kept.push_back(avail_copies[k]);
        end
        avail_copies = kept;
      end
      if (x.is_move && x.copy_ok && x.dest_in_grf && x.src0_in_grf &&
          loc[0] != x.dest_loc && avail_copies.size() < TABLE_DEPTH) begin
        fresh.dest = x.dest_loc;
        fresh.src = loc[0];
        avail_copies.push_back(fresh);
      end
      r.new_src0_loc = loc[0];
      r.new_src1_loc = loc[1];
      r.new_src2_loc = loc[2];
      r.any_rewritten = hit;
      expected_rewrites.push_back(r);
      accepted++;
    endfunction

    task flag_mismatch(string what, logic [LOC_BITS-1:0] got, logic [LOC_BITS-1:0] want);
      $display("mismatch at result %0d: %s got %h want %h", results_seen, what, got, want);
      errors++;
    endtask

    task check_rewrite(cpt_out_t got);
      cpt_out_t want;
      if (expected_rewrites.size() == 0) begin
        flag_mismatch("unexpected transfer", got.new_src0_loc, '0);
      end else begin
        want = expected_rewrites.pop_front();
        if (got.new_src0_loc !== want.new_src0_loc)
          flag_mismatch("new_src0_loc", got.new_src0_loc, want.new_src0_loc);
        if (got.new_src1_loc !== want.new_src1_loc)
          flag_mismatch("new_src1_loc", got.new_src1_loc, want.new_src1_loc);
        if (got.new_src2_loc !== want.new_src2_loc)
          flag_mismatch("new_src2_loc", got.new_src2_loc, want.new_src2_loc);
        if (got.any_rewritten !== want.any_rewritten)
          flag_mismatch("any_rewritten", loc_t'(got.any_rewritten),
                        loc_t'(want.any_rewritten));
      end
      results_seen++;
    endtask

    function int pending();
      return expected_rewrites.size();
    endfunction
  endclass

  copy_prop_sb sb = new();

  copy_propagation_table_top dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic loc_t at(int r, int off);
    return {REG_BITS'(r), OFFSET_BITS'(off)};
  endfunction

  function automatic cpt_in_t instr(logic bs, logic mv, loc_t dest, int cnt,
                                    loc_t s0, loc_t s1, loc_t s2);
    cpt_in_t x;
    x.block_start = bs;
    x.is_move = mv;
    x.copy_ok = 1'b1;
    x.dest_in_grf = 1'b1;
    x.dest_loc = dest;
    x.dest_count = COUNT_BITS'(cnt);
    x.src0_in_grf = 1'b1;
    x.src0_loc = s0;
    x.src1_in_grf = 1'b1;
    x.src1_loc = s1;
    x.src2_in_grf = 1'b1;
    x.src2_loc = s2;
    return x;
  endfunction

  // mostly a few registers and offsets so copies collide
  function automatic loc_t rand_loc();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) return at($urandom_range(0, 3), $urandom_range(0, 3));
    if (pick < 8) return at($urandom_range(0, 3), $urandom_range(0, 15));
    return loc_t'($urandom);
  endfunction

  function automatic cpt_in_t rand_instr();
    cpt_in_t x;
    x.block_start = ($urandom_range(0, 39) == 0);
    x.is_move = ($urandom_range(0, 1) == 1);
    x.copy_ok = ($urandom_range(0, 6) != 0);
    x.dest_in_grf = ($urandom_range(0, 9) != 0);
    x.dest_loc = rand_loc();
    x.dest_count = (x.is_move && $urandom_range(0, 4) != 0) ? COUNT_BITS'(1)
                                                             : COUNT_BITS'($urandom_range(0, 8));
    x.src0_in_grf = ($urandom_range(0, 6) != 0);
    x.src0_loc = rand_loc();
    x.src1_in_grf = ($urandom_range(0, 6) != 0);
    x.src1_loc = rand_loc();
    x.src2_in_grf = ($urandom_range(0, 6) != 0);
    x.src2_loc = rand_loc();
    return x;
  endfunction

  task automatic send_item(input cpt_in_t x);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= x;
    do @(posedge clk); while (!item_ready);
    sb.note_instr(x);
  endtask

  task automatic run_directed();
    cpt_in_t x;
    int      k;
    // chain of two copies, then a reader of both
    send_item(instr(1'b1, 1'b1, at(1, 0), 1, at(0, 0), at(5, 5), at(6, 6)));
    send_item(instr(1'b0, 1'b1, at(2, 0), 1, at(1, 0), at(1, 0), at(6, 6)));
    x = instr(1'b0, 1'b0, at(9, 0), 1, at(2, 0), at(1, 0), at(2, 0));
    x.src2_in_grf = 1'b0;
    send_item(x);
    // move onto itself after rewrite
    send_item(instr(1'b0, 1'b1, at(0, 0), 1, at(1, 0), '1, '0));
    x = instr(1'b0, 1'b1, '1, 1, '0, at(2, 0), at(1, 0));
    x.copy_ok = 1'b0;
    send_item(x);
    send_item(instr(1'b0, 1'b1, '1, 1, '0, '1, '1));
    // kill range running past the last offset
    send_item(instr(1'b0, 1'b1, at(3, 14), 1, at(7, 0), '1, at(3, 14)));
    send_item(instr(1'b0, 1'b1, at(4, 0), 1, at(7, 1), at(3, 14), '0));
    send_item(instr(1'b0, 1'b0, at(3, 14), 8, at(3, 14), at(4, 0), at(7, 1)));
    // zero count and non-register destination remove nothing
    send_item(instr(1'b0, 1'b0, at(4, 0), 0, at(3, 14), at(4, 0), at(4, 0)));
    x = instr(1'b0, 1'b0, at(4, 0), 8, at(4, 0), at(3, 15), at(4, 1));
    x.dest_in_grf = 1'b0;
    send_item(x);
    x = instr(1'b0, 1'b1, at(5, 1), 1, at(4, 0), at(4, 0), '1);
    x.src0_in_grf = 1'b0;
    send_item(x);
    // fill the table, then one more copy that gets dropped
    for (k = 0; k < TABLE_DEPTH + 1; k++)
      send_item(instr(k == 0, 1'b1, at(100 + k, 0), 0, at(200 + k, 0), at(100, 0),
                      at(99 + k, 0)));
    send_item(instr(1'b0, 1'b0, at(9, 1), 0, at(100 + TABLE_DEPTH, 0), at(100, 0),
                    at(99 + TABLE_DEPTH, 0)));
  endtask

  initial begin : receiver
    int stall;
    bit held;
    stall = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_valid && result_ready) sb.check_rewrite(result);
      if (stall > 0) begin
        stall--;
      end else if (!held && sb.accepted >= 150) begin
        held = 1'b1;
        stall = 200;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 10);
      end
      result_ready <= (stall == 0);
    end
  end

  initial begin : stimulus
    int n;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    idling_on = 1'b1;
    run_directed();
    for (n = 0; n < 500; n++) begin
      if (n == 420) idling_on = 1'b0;
      send_item(rand_instr());
    end
    item_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (2 * TABLE_DEPTH + 8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #3_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/cpt_pkg.sv
hw/rtl/cpt_cell.sv
hw/rtl/cpt_head.sv
hw/rtl/copy_propagation_table_top.sv
tb/testbench.sv
